// ----- src/lcu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcu_pkg: shared types, codes and tables for the code page to UTF-8 converter
// Holds the character table lookup and the work word passed from front to back.
// ----------------------------------------------------------------------------
package lcu_pkg;

	localparam int QueueDepth = 4;
	localparam int QueueAw    = $clog2(QueueDepth);

	typedef enum logic [1:0] {
		TBL_BASIC    = 2'd0,
		TBL_SPECIAL  = 2'd1,
		TBL_GREEK    = 2'd2,
		TBL_CYRILLIC = 2'd3
	} tbl_t;

	localparam logic [7:0] B_NUL     = 8'h00;
	localparam logic [7:0] B_TWO     = 8'h01;
	localparam logic [7:0] B_TAB     = 8'h09;
	localparam logic [7:0] B_LF      = 8'h0A;
	localparam logic [7:0] B_CR      = 8'h0D;
	localparam logic [7:0] B_NL      = 8'h15;
	localparam logic [7:0] B_SPECIAL = 8'h1D;
	localparam logic [7:0] B_ONE     = 8'h7F;
	localparam logic [7:0] B_GREEK   = 8'h83;
	localparam logic [7:0] B_KOPPA   = 8'h85;
	localparam logic [7:0] B_CYR     = 8'h87;
	localparam logic [7:0] B_SWALLOW = 8'h88;
	localparam logic [7:0] B_KOPPA2  = 8'hAF;
	localparam logic [7:0] B_OMEGA   = 8'h81;

	// Work word: up to two code points plus an optional literal byte and terminator.
	typedef struct packed {
		logic [15:0] cp0;
		logic [15:0] cp1;
		logic        has_lit;
		logic [7:0]  lit;
		logic        eor;
	} work_t;

	function automatic logic [31:0] rom_lookup(input logic [1:0] t, input logic [7:0] b);
		logic [15:0] c0;
		logic [15:0] c1;
		c0 = 16'h0;
		c1 = 16'h0;
		case (t)
			TBL_BASIC: begin
				if (b >= 8'h20 && b <= 8'h7D && b != 8'h5E) c0 = {8'h00, b};
				else if (b == 8'h5E) c0 = 16'h0302;
				else if (b == 8'h7E) c0 = 16'h0303;
				else if (b >= 8'h80 && b <= 8'hAF) c0 = 16'h0410 + {8'h00, b - 8'h80};
				else if (b >= 8'hE0 && b <= 8'hEF) c0 = 16'h0440 + {8'h00, b - 8'hE0};
				else begin
					case (b)
						8'hB0: c0 = 16'h0101; 8'hB1: c0 = 16'h0301; 8'hB2: c0 = 16'h00E4;
						8'hB3: c0 = 16'h0328; 8'hB4: c0 = 16'h01DF;
						8'hB5: begin c0 = 16'h0063; c1 = 16'h0323; end
						8'hB6: c0 = 16'h010D;
						8'hB7: begin c0 = 16'h010D; c1 = 16'h0323; end
						8'hB8: c0 = 16'h03B4; 8'hB9: c0 = 16'h0113; 8'hBB: c0 = 16'h0307;
						8'hBC: c0 = 16'h0308; 8'hBD: c0 = 16'h025B; 8'hBE: c0 = 16'h02A1;
						8'hBF: c0 = 16'h032F; 8'hC0: c0 = 16'h00E7; 8'hC1: c0 = 16'h0263;
						8'hC2: c0 = 16'h0281; 8'hC3: c0 = 16'h0127; 8'hC4: c0 = 16'h0304;
						8'hC5: c0 = 16'h012B; 8'hC6: c0 = 16'h0268;
						8'hC7: begin c0 = 16'h0268; c1 = 16'h0304; end
						8'hC8: c0 = 16'h030A; 8'hC9: c0 = 16'h0325; 8'hCA: c0 = 16'h1E33;
						8'hCB: c0 = 16'h028E; 8'hCC: c0 = 16'h019B; 8'hCD: c0 = 16'h002D;
						8'hCE: begin c0 = 16'h019B; c1 = 16'h0323; end
						8'hCF: c0 = 16'h026B; 8'hD0: c0 = 16'h2C62; 8'hD1: c0 = 16'h014B;
						8'hD2: c0 = 16'h014D; 8'hD3: c0 = 16'h00F6; 8'hD4: c0 = 16'h022B;
						8'hD5: c0 = 16'h0254;
						8'hD6: begin c0 = 16'h0254; c1 = 16'h0304; end
						8'hD7: c0 = 16'h1E57;
						8'hD8: begin c0 = 16'h0071; c1 = 16'h0307; end
						8'hD9: c0 = 16'h00DF; 8'hDA: c0 = 16'h007E; 8'hDB: c0 = 16'h0300;
						8'hDC: c0 = 16'h0323; 8'hDD: c0 = 16'h0161; 8'hDE: c0 = 16'h1E6D;
						8'hDF: c0 = 16'h0306; 8'hF0: c0 = 16'h03D1; 8'hF1: c0 = 16'h016B;
						8'hF2: c0 = 16'h00FC; 8'hF3: c0 = 16'h01D6; 8'hF4: c0 = 16'h0259;
						8'hF5: begin c0 = 16'h0259; c1 = 16'h0304; end
						8'hF6: c0 = 16'h030C; 8'hF7: c0 = 16'h02B7; 8'hF8: c0 = 16'h0266;
						8'hF9: c0 = 16'h03C7; 8'hFA: c0 = 16'h0292; 8'hFB: c0 = 16'h01EF;
						8'hFC: c0 = 16'h017E; 8'hFD: c0 = 16'h0294; 8'hFE: c0 = 16'h0295;
						8'hFF: c0 = 16'h028C;
						default: c0 = 16'h0;
					endcase
				end
			end
			TBL_SPECIAL: begin
				case (b)
					8'h41: c0 = 16'h04D4; 8'h44: c0 = 16'h0111; 8'h4C: c0 = 16'h026C;
					8'h54: c0 = 16'h0167; 8'h5E: c0 = 16'h0311; 8'h61: c0 = 16'h00E6;
					8'h62: c0 = 16'h0180; 8'h63: c0 = 16'h0255; 8'h64: c0 = 16'h00F0;
					8'h65: c0 = 16'h0153; 8'h67: c0 = 16'h01E5; 8'h68: c0 = 16'h1E2B;
					8'h69: c0 = 16'h0131; 8'h6A: c0 = 16'h0237; 8'h6F: c0 = 16'h00F8;
					8'h72: c0 = 16'h027E; 8'h73: c0 = 16'h0283; 8'h74: c0 = 16'h00FE;
					8'h78: c0 = 16'h1D9A; 8'hA3: c0 = 16'h0260; 8'hA5: c0 = 16'h0467;
					8'hA7: c0 = 16'h0455; 8'hAB: c0 = 16'h0459; 8'hAD: c0 = 16'h045A;
					8'hAE: c0 = 16'h046B; 8'hB0: c0 = 16'h030B; 8'hBF: c0 = 16'h032E;
					8'hDB: c0 = 16'h030F; 8'hE0: c0 = 16'h0281; 8'hEE: c0 = 16'h0454;
					8'hEF: c0 = 16'h017E; 8'hF8: c0 = 16'h0195; 8'hFA: c0 = 16'h0452;
					default: c0 = 16'h0;
				endcase
			end
			TBL_GREEK: begin
				case (b)
					8'h90: c0 = 16'h0344;
					8'h91: begin c0 = 16'h0314; c1 = 16'h0301; end
					8'h92: begin c0 = 16'h0313; c1 = 16'h0301; end
					8'h93: c0 = 16'h0301;
					8'h9A: begin c0 = 16'h0308; c1 = 16'h0300; end
					8'h9B: begin c0 = 16'h0314; c1 = 16'h0300; end
					8'h9C: begin c0 = 16'h0313; c1 = 16'h0300; end
					8'h9D: begin c0 = 16'h0314; c1 = 16'h0342; end
					8'h9E: c0 = 16'h0387;
					8'hA0: c0 = 16'h0314; 8'hA1: c0 = 16'h0313; 8'hA3: c0 = 16'h0308;
					8'hA4: c0 = 16'h0391; 8'hA5: c0 = 16'h0392; 8'hA6: c0 = 16'h03A7;
					8'hA7: c0 = 16'h0394; 8'hA8: c0 = 16'h0395; 8'hA9: c0 = 16'h03A6;
					8'hAA: c0 = 16'h0393; 8'hAB: c0 = 16'h0397; 8'hAC: c0 = 16'h0399;
					8'hAD: c0 = 16'h1FF3; 8'hAE: c0 = 16'h039A; 8'hAF: c0 = 16'h039B;
					8'hB0: c0 = 16'h039C; 8'hB1: c0 = 16'h039D; 8'hB2: c0 = 16'h039F;
					8'hB3: c0 = 16'h03A0; 8'hB4: c0 = 16'h0398; 8'hB5: c0 = 16'h03A1;
					8'hB6: c0 = 16'h03A3; 8'hB7: c0 = 16'h03A4; 8'hB8: c0 = 16'h03A5;
					8'hB9: c0 = 16'h1FC3; 8'hBA: c0 = 16'h03A9; 8'hBB: c0 = 16'h039E;
					8'hBC: c0 = 16'h03A8; 8'hBD: c0 = 16'h0396;
					8'hC0: begin c0 = 16'h0313; c1 = 16'h0342; end
					8'hC1: c0 = 16'h0300; 8'hC2: c0 = 16'h03B1; 8'hC3: c0 = 16'h03B2;
					8'hC4: c0 = 16'h03C7; 8'hC5: c0 = 16'h03B4; 8'hC6: c0 = 16'h03B5;
					8'hC7: c0 = 16'h03C6; 8'hC8: c0 = 16'h03B3; 8'hC9: c0 = 16'h03B7;
					8'hCA: c0 = 16'h03B9; 8'hCB: c0 = 16'h03C2; 8'hCC: c0 = 16'h03BA;
					8'hCD: c0 = 16'h03BB; 8'hCE: c0 = 16'h03BC; 8'hCF: c0 = 16'h03BD;
					8'hD0: c0 = 16'h03BF; 8'hD1: c0 = 16'h03C0; 8'hD2: c0 = 16'h03B8;
					8'hD3: c0 = 16'h03C1; 8'hD4: c0 = 16'h03C3; 8'hD5: c0 = 16'h03C4;
					8'hD6: c0 = 16'h03C5; 8'hD7: c0 = 16'h1FB3; 8'hD8: c0 = 16'h03C9;
					8'hD9: c0 = 16'h03BE; 8'hDA: c0 = 16'h03C8; 8'hDB: c0 = 16'h03B6;
					8'hDC: c0 = 16'h0342;
					default: c0 = 16'h0;
				endcase
			end
			default: begin
				case (b)
					8'h83: begin c0 = 16'h0433; c1 = 16'h0311; end
					8'h84: c0 = 16'h0431; 8'h86: c0 = 16'h044E; 8'h93: c0 = 16'h0436;
					8'h96: c0 = 16'h042E; 8'h9A: c0 = 16'h0418; 8'h9B: c0 = 16'h0421;
					8'h9E: c0 = 16'h0410; 8'h9F: c0 = 16'h041F; 8'hA0: c0 = 16'h0420;
					8'hA2: c0 = 16'h041E; 8'hA3: c0 = 16'h041B; 8'hA4: c0 = 16'h0414;
					8'hA8: c0 = 16'h0417; 8'hAA: c0 = 16'h041A; 8'hAC: c0 = 16'h0415;
					8'hAD: c0 = 16'h0413; 8'hAE: c0 = 16'h041C; 8'hB1: c0 = 16'h041D;
					8'hB3: c0 = 16'h0445; 8'hB8: c0 = 16'h044A; 8'hB9: c0 = 16'h0444;
					8'hBA: c0 = 16'h0438; 8'hBB: c0 = 16'h0441; 8'hBC: c0 = 16'h0432;
					8'hBD: c0 = 16'h0443; 8'hBE: c0 = 16'h0430; 8'hBF: c0 = 16'h043F;
					8'hC0: c0 = 16'h0440; 8'hC1: c0 = 16'h0448; 8'hC2: c0 = 16'h043E;
					8'hC3: c0 = 16'h043B; 8'hC4: c0 = 16'h0434; 8'hC5: c0 = 16'h044C;
					8'hC6: c0 = 16'h0442; 8'hC8: c0 = 16'h0437; 8'hCA: c0 = 16'h043A;
					8'hCB: c0 = 16'h044B; 8'hCC: c0 = 16'h0435; 8'hCD: c0 = 16'h0433;
					8'hCE: c0 = 16'h043C; 8'hCF: c0 = 16'h0446; 8'hD0: c0 = 16'h0447;
					8'hD1: c0 = 16'h043D; 8'hD2: c0 = 16'h044F; 8'hD3: c0 = 16'h0425;
					8'hD5: c0 = 16'h0463; 8'hD8: c0 = 16'hA657; 8'hDA: c0 = 16'h0467;
					8'hE7: c0 = 16'h046B; 8'hE8: c0 = 16'h0415; 8'hE9: c0 = 16'h0065;
					8'hF2: c0 = 16'h0461; 8'hF3: c0 = 16'h046C; 8'hF4: c0 = 16'h046D;
					8'hF5: c0 = 16'h0464; 8'hF6: c0 = 16'h0465;
					default: c0 = 16'h0;
				endcase
			end
		endcase
		return {c0, c1};
	endfunction

endpackage

// ----- src/lcu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcu_front: byte classifier
// Tracks mode, table and lookahead flags; turns each byte into a work word.
// ----------------------------------------------------------------------------
module lcu_front import lcu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_record,
	output logic       wr_en,
	output work_t      wr_word,
	input  logic       q_full
);
	logic       two_q, two_d;
	tbl_t       tbl_q, tbl_d;
	logic       drop_q, drop_d;
	logic       koppa_q, koppa_d;
	logic       swal_q, swal_d;
	logic       acc;
	logic       done;
	logic [31:0] lk;
	tbl_t       tbl_use;
	work_t      w;

	assign full  = q_full;
	assign acc   = push && !q_full;
	assign wr_en = acc;

	always_comb begin
		two_d   = two_q;
		tbl_d   = tbl_q;
		drop_d  = drop_q;
		koppa_d = koppa_q;
		swal_d  = 1'b0;
		done    = 1'b0;
		tbl_use = tbl_q;
		w       = '0;
		w.eor   = end_of_record;
		lk      = '0;
		if (swal_q) begin
			if (two_q && data_byte == B_OMEGA) w.cp0 = 16'h0475;
			else if (two_q && data_byte == B_GREEK) w.cp0 = 16'h0467;
		end else begin
			if (koppa_q) begin
				koppa_d = 1'b0;
				if (data_byte == B_KOPPA2) begin
					w.cp0 = 16'h03DD;
					done  = 1'b1;
				end
			end
			if (drop_q) begin
				drop_d = 1'b0;
				if (data_byte == B_CR) done = 1'b1;
			end
			if (!done) begin
				case (data_byte)
					B_NUL: ;
					B_TWO: two_d = 1'b1;
					B_TAB: begin
						w.has_lit = 1'b1;
						w.lit     = B_TAB;
					end
					B_LF: begin
						w.has_lit = 1'b1;
						w.lit     = B_LF;
						drop_d    = 1'b1;
					end
					B_NL: begin
						w.has_lit = 1'b1;
						w.lit     = B_LF;
					end
					B_SPECIAL: tbl_d = TBL_SPECIAL;
					B_ONE: two_d = 1'b0;
					B_GREEK: tbl_d = TBL_GREEK;
					B_KOPPA: if (two_q) koppa_d = 1'b1;
					B_CYR: if (two_q) tbl_d = TBL_CYRILLIC;
					B_SWALLOW: swal_d = 1'b1;
					default: begin
						if (two_q && data_byte < B_ONE) begin
							tbl_use = TBL_BASIC;
							two_d   = 1'b0;
						end
						lk    = rom_lookup(tbl_use, data_byte);
						w.cp0 = lk[31:16];
						w.cp1 = lk[15:0];
						tbl_d = (tbl_use == TBL_SPECIAL) ? TBL_BASIC : tbl_use;
					end
				endcase
			end
		end
		if (end_of_record) begin
			two_d   = 1'b0;
			tbl_d   = TBL_BASIC;
			drop_d  = 1'b0;
			koppa_d = 1'b0;
			swal_d  = 1'b0;
		end
	end

	assign wr_word = w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_q   <= 1'b0;
			tbl_q   <= TBL_BASIC;
			drop_q  <= 1'b0;
			koppa_q <= 1'b0;
			swal_q  <= 1'b0;
		end else if (acc) begin
			two_q   <= two_d;
			tbl_q   <= tbl_d;
			drop_q  <= drop_d;
			koppa_q <= koppa_d;
			swal_q  <= swal_d;
		end
	end

endmodule

// ----- src/lcu_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcu_queue: work word queue
// Small register FIFO between classifier and byte emitter.
// ----------------------------------------------------------------------------
module lcu_queue import lcu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  work_t wr_word,
	output logic  q_full,
	input  logic  rd_en,
	output logic  q_empty,
	output work_t rd_word
);
	work_t              mem_q [QueueDepth];
	logic [QueueAw-1:0] wp_q, rp_q;
	logic [QueueAw:0]   cnt_q;

	assign q_full  = cnt_q == (QueueAw+1)'(QueueDepth);
	assign q_empty = cnt_q == '0;
	assign rd_word = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (rd_en) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QueueAw+1)'(wr_en) - (QueueAw+1)'(rd_en);
		end
	end

endmodule

// ----- src/lcu_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcu_back: UTF-8 byte emitter
// Expands one work word into its byte run, at most one byte per cycle while pop keeps the register free.
// ----------------------------------------------------------------------------
module lcu_back import lcu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  work_t      rd_word,
	output logic       rd_en,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] utf8_byte,
	output logic       last_of_run,
	output logic       record_end
);
	logic [7:0] seq [7];
	logic [6:0] vmask;
	logic [2:0] idx_q;
	logic [2:0] nxt;
	logic       found;
	logic [2:0] nxt2;
	logic       more;
	logic       vld_q;
	logic       can_load;
	logic [15:0] c0, c1;

	assign c0 = rd_word.cp0;
	assign c1 = rd_word.cp1;

	always_comb begin
		vmask = '0;
		seq[0] = rd_word.lit;
		vmask[0] = rd_word.has_lit;
		if (c0 < 16'h0080) begin
			seq[1] = c0[7:0];
			seq[2] = '0;
			seq[3] = '0;
			vmask[1] = c0 != '0;
		end else if (c0 < 16'h0800) begin
			seq[1] = {3'b110, c0[10:6]};
			seq[2] = {2'b10, c0[5:0]};
			seq[3] = '0;
			vmask[2:1] = 2'b11;
		end else begin
			seq[1] = {4'b1110, c0[15:12]};
			seq[2] = {2'b10, c0[11:6]};
			seq[3] = {2'b10, c0[5:0]};
			vmask[3:1] = 3'b111;
		end
		if (c1 < 16'h0800) begin
			seq[4] = {3'b110, c1[10:6]};
			seq[5] = {2'b10, c1[5:0]};
			vmask[5:4] = {2{c1 != '0}};
		end else begin
			seq[4] = '0;
			seq[5] = '0;
		end
		seq[6] = B_NUL;
		vmask[6] = rd_word.eor;
	end

	always_comb begin
		found = 1'b0;
		nxt   = '0;
		for (int i = 0; i < 7; i++) begin
			if (!found && vmask[i] && 3'(i) >= idx_q) begin
				found = 1'b1;
				nxt   = 3'(i);
			end
		end
		more = 1'b0;
		nxt2 = '0;
		for (int i = 0; i < 7; i++) begin
			if (!more && vmask[i] && 3'(i) > nxt) begin
				more = 1'b1;
				nxt2 = 3'(i);
			end
		end
	end

	assign empty    = !vld_q;
	assign can_load = !vld_q || pop;
	assign rd_en    = !q_empty && can_load && (!found || !more);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (can_load) begin
			vld_q <= !q_empty && found;
			if (!q_empty && found && more) idx_q <= nxt2;
			else if (!q_empty) idx_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) begin
			utf8_byte   <= seq[nxt];
			last_of_run <= !more;
			record_end  <= nxt == 3'd6;
		end
	end

endmodule

// ----- src/legacy_codepage_to_utf8.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// legacy_codepage_to_utf8: code page to UTF-8 converter
//
//  channel | handshake     | words
//  in      | push / full   | data_byte, end_of_record
//  out     | empty / pop   | utf8_byte, last_of_run, record_end
//
// At most one output byte per cycle, while pop keeps the output register free; the
// emitter takes the next work word once the last byte of the current run is loaded.
// The classifier takes a byte each cycle while the 4-entry queue has room.
// An accepted byte passes the queue and then the output register to reach utf8_byte.
// Reset clears flags and queue. Output register holds its byte until pop.
// ----------------------------------------------------------------------------
module legacy_codepage_to_utf8 import lcu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_record,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] utf8_byte,
	output logic       last_of_run,
	output logic       record_end
);
	logic  wr_en, q_full, rd_en, q_empty;
	work_t wr_word, rd_word;

	lcu_front u_front (
		.clk, .arst_n, .push, .full, .data_byte, .end_of_record,
		.wr_en, .wr_word, .q_full
	);

	lcu_queue u_queue (
		.clk, .arst_n, .wr_en, .wr_word, .q_full, .rd_en, .q_empty, .rd_word
	);

	lcu_back u_back (
		.clk, .arst_n, .q_empty, .rd_word, .rd_en, .empty, .pop,
		.utf8_byte, .last_of_run, .record_end
	);

endmodule

// ----- tb/lcu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcu_checker: output checker for the code page to UTF-8 converter
// Watches both queues, works out the UTF-8 words each accepted input byte
// should produce and compares them, oldest first, with the words popped.
// ----------------------------------------------------------------------------
module lcu_checker import lcu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_record,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] utf8_byte,
	input  logic       last_of_run,
	input  logic       record_end,
	output int         fail_count,
	output int         pending_words,
	output int         words_seen,
	output int         records_seen
);

	typedef struct packed {
		logic [7:0] byte_val;
		logic       last;
		logic       rec_end;
	} utf8_word_t;

	utf8_word_t expected_words[$];
	utf8_word_t run_words[$];

	logic       mode2;
	tbl_t       cur_tbl;
	logic       drop_cr;
	logic       koppa_armed;
	logic       swallow;

	assign pending_words = expected_words.size();

	function automatic void emit_byte(input logic [7:0] b);
		utf8_word_t w;
		w.byte_val = b;
		w.last = 1'b0;
		w.rec_end = 1'b0;
		run_words.push_back(w);
	endfunction

	function automatic void emit_cp(input logic [15:0] cp);
		if (cp == 16'h0) return;
		if (cp < 16'h80) begin
			emit_byte(cp[7:0]);
		end else if (cp < 16'h800) begin
			emit_byte(8'hC0 | cp[10:6]);
			emit_byte(8'h80 | cp[5:0]);
		end else begin
			emit_byte(8'hE0 | cp[15:12]);
			emit_byte(8'h80 | cp[11:6]);
			emit_byte(8'h80 | cp[5:0]);
		end
	endfunction

	function automatic void table_lookup(input logic [7:0] b);
		logic [31:0] cps;
		cps = rom_lookup(cur_tbl, b);
		emit_cp(cps[31:16]);
		emit_cp(cps[15:0]);
	endfunction

	function automatic void decode_byte(input logic [7:0] b);
		case (b)
			B_NUL: ;
			B_TWO: mode2 = 1'b1;
			B_TAB: emit_byte(B_TAB);
			B_LF: begin
				emit_byte(B_LF);
				drop_cr = 1'b1;
			end
			B_NL: emit_byte(B_LF);
			B_SPECIAL: cur_tbl = TBL_SPECIAL;
			B_ONE: mode2 = 1'b0;
			B_GREEK: cur_tbl = TBL_GREEK;
			B_KOPPA: if (mode2) koppa_armed = 1'b1;
			B_CYR: if (mode2) cur_tbl = TBL_CYRILLIC;
			B_SWALLOW: swallow = 1'b1;
			default: begin
				if (mode2 && b < B_ONE) begin
					cur_tbl = TBL_BASIC;
					mode2 = 1'b0;
				end
				table_lookup(b);
				if (cur_tbl == TBL_SPECIAL) cur_tbl = TBL_BASIC;
			end
		endcase
	endfunction

	function automatic void clear_state();
		mode2 = 1'b0;
		cur_tbl = TBL_BASIC;
		drop_cr = 1'b0;
		koppa_armed = 1'b0;
		swallow = 1'b0;
	endfunction

	function automatic void convert_byte(input logic [7:0] b, input logic eor);
		logic handled;
		utf8_word_t w;
		handled = 1'b0;
		run_words.delete();
		if (swallow) begin
			swallow = 1'b0;
			if (mode2) begin
				if (b == B_OMEGA) emit_cp(16'h0475);
				else if (b == B_GREEK) emit_cp(16'h0467);
			end
		end else begin
			if (koppa_armed) begin
				koppa_armed = 1'b0;
				if (b == B_KOPPA2) begin
					emit_cp(16'h03DD);
					handled = 1'b1;
				end
			end
			if (drop_cr) begin
				drop_cr = 1'b0;
				if (b == B_CR) handled = 1'b1;
			end
			if (!handled) decode_byte(b);
		end
		if (eor) begin
			w.byte_val = B_NUL;
			w.last = 1'b0;
			w.rec_end = 1'b1;
			run_words.push_back(w);
			clear_state();
		end
		if (run_words.size() > 0) run_words[run_words.size() - 1].last = 1'b1;
		foreach (run_words[i]) expected_words.push_back(run_words[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		utf8_word_t e;
		if (!arst_n) begin
			clear_state();
			expected_words.delete();
			fail_count <= 0;
			words_seen <= 0;
			records_seen <= 0;
		end else begin
			if (pop && !empty) begin
				words_seen <= words_seen + 1;
				if (record_end) records_seen <= records_seen + 1;
				if (expected_words.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected word %h last %b end %b", $time,
							utf8_byte, last_of_run, record_end);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_words.pop_front();
					if (e.byte_val !== utf8_byte || e.last !== last_of_run ||
						e.rec_end !== record_end) begin
						if (fail_count < 10)
							$display("%0t: expected %h/%b/%b got %h/%b/%b", $time,
								e.byte_val, e.last, e.rec_end,
								utf8_byte, last_of_run, record_end);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (push && !full) convert_byte(data_byte, end_of_record);
		end
	end

endmodule

// ----- tb/tb_legacy_codepage_to_utf8.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_legacy_codepage_to_utf8: testbench for the code page to UTF-8 converter
// Feeds directed control sequences and random records with random idling on
// both queues; the checker predicts each UTF-8 word and reports mismatches.
// ----------------------------------------------------------------------------
module tb_legacy_codepage_to_utf8;
	import lcu_pkg::*;

	localparam int WatchdogLimit = 2000;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] data_byte;
	logic       end_of_record;
	logic       empty;
	logic       pop;
	logic [7:0] utf8_byte;
	logic       last_of_run;
	logic       record_end;
	int         fail_count;
	int         pending_words;
	int         words_seen;
	int         records_seen;
	int         bytes_sent;
	int         idle_cycles = 0;
	logic       calm;

	legacy_codepage_to_utf8 i_dut (.*);

	lcu_checker i_checker (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= calm ? 1'b1 : ($urandom_range(99) >= 26);
		end
	end

	always @(posedge clk) begin
		if (arst_n && !((push && !full) || (pop && !empty))) idle_cycles <= idle_cycles + 1;
		else idle_cycles <= 0;
		if (idle_cycles >= WatchdogLimit) begin
			$display("watchdog expired after %0d bytes", bytes_sent);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eor);
		while (!calm && $urandom_range(99) < 26) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		end_of_record <= eor;
		@(posedge clk);
		while (full) @(posedge clk);
		bytes_sent++;
	endtask

	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		case ($urandom_range(9))
			0: b = B_TWO;
			1: b = B_GREEK;
			2: b = B_CYR;
			3: b = B_SPECIAL;
			4: b = B_SWALLOW;
			5: b = B_KOPPA;
			6: b = B_LF;
			7: b = 8'($urandom_range(8'h20, 8'h7E));
			default: b = 8'($urandom_range(255));
		endcase
		return b;
	endfunction

	task automatic send_record(input int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = pick_byte();
			if (b == B_SWALLOW && $urandom_range(1) == 1 && i < len - 1) begin
				send_byte(b, 1'b0);
				i++;
				b = $urandom_range(1) ? B_OMEGA : B_GREEK;
			end else if (b == B_KOPPA && i < len - 1 && $urandom_range(1) == 1) begin
				send_byte(b, 1'b0);
				i++;
				b = B_KOPPA2;
			end else if (b == B_LF && i < len - 1 && $urandom_range(1) == 1) begin
				send_byte(b, 1'b0);
				i++;
				b = B_CR;
			end
			send_byte(b, i == len - 1);
		end
	endtask

	initial begin
		logic [7:0] directed[$];
		push = 1'b0;
		data_byte = 8'h00;
		end_of_record = 1'b0;
		arst_n = 1'b0;
		calm = 1'b0;
		bytes_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{8'h00, 8'h41, 8'hFF, 8'h09, 8'h0A, 8'h0D, 8'h0A, 8'h41, 8'h15,
			8'h1D, 8'h61, 8'h83, 8'hA4, 8'h01, 8'h85, 8'hAF, 8'h85, 8'h41,
			8'h01, 8'h87, 8'hD8, 8'h88, 8'h81, 8'h01, 8'h88};
		foreach (directed[i]) send_byte(directed[i], 1'b0);
		send_byte(8'h83, 1'b1);
		send_byte(8'h5E, 1'b0);
		send_byte(8'h7E, 1'b1);

		while (bytes_sent < 230) send_record($urandom_range(1, 12));
		calm = 1'b1;
		while (bytes_sent < 300) send_record($urandom_range(1, 12));
		calm = 1'b0;
		while (bytes_sent < 369) begin
			send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
		end
		send_byte(8'h00, 1'b1);
		push <= 1'b0;

		while (pending_words != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("sent %0d bytes, checked %0d UTF-8 words over %0d records",
			bytes_sent, words_seen, records_seen);
		if (fail_count == 0 && pending_words == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("mismatches: %0d, words left: %0d", fail_count, pending_words);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
